FILE: src/rbd_pkg.sv
// Shared types, constants and channel helpers for the RGB565 2x2 box downsampler.
// No dependencies; used by every module under src except rbd_line_ram.
package rbd_pkg;

  localparam int DEF_MAX_WIDTH = 1024;

  // compare width for widths and heights (holds MAX_WIDTH up to 65535, plus one)
  localparam int CMP_W = 17;

  localparam int PIX_W = 16;
  localparam int SUM_W = 22;

  localparam logic [10:0] RST_SOURCE_WIDTH  = 11'd320;
  localparam logic [15:0] RST_SOURCE_HEIGHT = 16'd240;

  typedef enum logic {
    REG_SOURCE_WIDTH  = 1'b0,
    REG_SOURCE_HEIGHT = 1'b1
  } reg_index_t;

  // one beat handed from the front stage to the output stage
  typedef struct packed {
    logic              valid;
    logic              pass;   // pixel bypasses the filter
    logic              eof;
    logic [PIX_W-1:0]  px;
    logic [SUM_W-1:0]  pair;   // packed sums of the current horizontal pair
  } stage_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_req_t;

  // packed sums: red 21-15, green 14-7, blue 6-0
  function automatic logic [SUM_W-1:0] unpack_channels(input logic [PIX_W-1:0] px);
    unpack_channels = {2'b00, px[15:11], 2'b00, px[10:5], 2'b00, px[4:0]};
  endfunction

  // divide each channel sum by four with truncation, repack as RGB565
  function automatic logic [PIX_W-1:0] average_of(input logic [SUM_W-1:0] s);
    average_of = {s[21:17], s[14:9], s[6:2]};
  endfunction

endpackage

FILE: src/rbd_line_ram.sv
// Line store of per-column pair sums: one write port, one registered read port.
// Depends on nothing but its parameters.
module rbd_line_ram #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int DW    = 22
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/rbd_front.sv
// Position counters, horizontal pair sum and line store access for each input beat.
// Depends on rbd_pkg.
module rbd_front #(
  parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH,
  parameter int CW        = 10,
  parameter int AW        = 9
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic [rbd_pkg::PIX_W-1:0] px,
  input  logic [10:0]              source_width,
  input  logic [15:0]              source_height,
  output rbd_pkg::stage_t          s0,
  output rbd_pkg::mem_req_t        mem_req,
  output logic [AW-1:0]            mem_addr,
  output logic [rbd_pkg::SUM_W-1:0] mem_wdata
);

  localparam int CMPW = rbd_pkg::CMP_W;

  logic [CW-1:0]             col_r, col_nxt;
  logic [15:0]               row_r, row_nxt;
  logic [rbd_pkg::SUM_W-1:0] pair_sum_r, pair_sum_nxt;

  logic [CMPW-1:0] sw, mw, w, we_w, he, h, x1, y1, used_w, used_h, x, y;
  logic            row_end, frame_end, bypass, in_use;
  logic [rbd_pkg::SUM_W-1:0] ch, pair;
  logic [CW-1:0]   idx_full;

  always_comb begin
    sw = CMPW'(source_width);
    mw = CMPW'(MAX_WIDTH);
    w  = (sw > mw) ? mw : sw;
    h  = CMPW'(source_height);
    we_w = (w == '0) ? CMPW'(1) : w;
    he   = (h == '0) ? CMPW'(1) : h;
    x  = CMPW'(col_r);
    y  = CMPW'(row_r);
    x1 = x + CMPW'(1);
    y1 = y + CMPW'(1);
    row_end   = x1 >= we_w;
    frame_end = row_end && (y1 >= he);
    bypass = (w < CMPW'(2)) || (h < CMPW'(2));
    used_w = {w[CMPW-1:1], 1'b0};
    used_h = {h[CMPW-1:1], 1'b0};
    in_use = !bypass && (x < used_w) && (y < used_h);

    ch   = rbd_pkg::unpack_channels(px);
    pair = pair_sum_r + ch;
    idx_full  = col_r >> 1;
    mem_addr  = idx_full[AW-1:0];
    mem_wdata = pair;

    mem_req.we = accept && in_use && col_r[0] && !row_r[0];
    mem_req.re = accept && in_use && col_r[0] && row_r[0];

    s0.valid = (accept && bypass) || mem_req.re;
    s0.pass  = bypass;
    s0.eof   = bypass ? frame_end : ((x1 >= used_w) && (y1 >= used_h));
    s0.px    = px;
    s0.pair  = pair;

    pair_sum_nxt = pair_sum_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    if (accept) begin
      if (in_use && !col_r[0]) begin
        pair_sum_nxt = ch;
      end
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? 16'd0 : 16'(y1);
      end else begin
        col_nxt = CW'(x1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      pair_sum_r <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      pair_sum_r <= pair_sum_nxt;
    end
  end

endmodule

FILE: src/rbd_back.sv
// Adds the line store sum to the pair and averages, or passes a bypass pixel through, and holds the result beat.
// Depends on rbd_pkg.
module rbd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rbd_pkg::stage_t           s0,
  input  logic [rbd_pkg::SUM_W-1:0] rd_data,
  output logic                      take,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [rbd_pkg::PIX_W-1:0] out_tdata,
  output logic                      out_tlast
);

  logic                      s1_valid_r, s1_valid_nxt;
  logic                      s1_pass_r, s1_eof_r;
  logic [rbd_pkg::PIX_W-1:0] s1_px_r;
  logic [rbd_pkg::SUM_W-1:0] s1_pair_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [rbd_pkg::PIX_W-1:0] out_px_r;
  logic                      out_eof_r;
  logic                      s1_move;
  logic [rbd_pkg::SUM_W-1:0] total;

  always_comb begin
    s1_move = s1_valid_r && (!out_valid_r || out_tready);
    take    = !s1_valid_r || s1_move;
    total   = rd_data + s1_pair_r;

    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = s0.valid;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s0.valid) begin
      s1_pass_r <= s0.pass;
      s1_eof_r  <= s0.eof;
      s1_px_r   <= s0.px;
      s1_pair_r <= s0.pair;
    end
    if (s1_move) begin
      out_px_r  <= s1_pass_r ? s1_px_r : rbd_pkg::average_of(total);
      out_eof_r <= s1_eof_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_px_r;
  assign out_tlast  = out_eof_r;

endmodule

FILE: src/rgb565_box_downsample_2x.sv
// Takes one RGB565 pixel per clock in raster order while the output path has room,
// and emits the 2x2 box average on every odd row at every odd column, via the s1 and
// output registers after the pixel that completes the block; a trailing odd column or
// row is dropped, and a frame under two pixels wide or high passes through unchanged.
// Each odd-column pixel costs one access to the line store (a pair-sum write on even
// rows, a read on odd rows) and even-column pixels none, which permits one pixel per
// cycle. Result beats are held in a two-deep output path, so input keeps flowing while
// one result waits. No clearing pass follows reset; the first frame after reset must
// start at row zero. Write source_width and source_height only between frames.
// Top level; depends on rbd_pkg, rbd_front, rbd_back and rbd_line_ram.
module rgb565_box_downsample_2x #(
  parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] pixel_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] pixel_out
  output logic        out_tlast,   // end_of_frame
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  logic [10:0] source_width_r;
  logic [15:0] source_height_r;

  rbd_pkg::stage_t           s0;
  rbd_pkg::mem_req_t         mem_req;
  logic [AW-1:0]             mem_addr;
  logic [rbd_pkg::SUM_W-1:0] mem_wdata, mem_rdata;
  logic                      take, accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_width_r  <= rbd_pkg::RST_SOURCE_WIDTH;
      source_height_r <= rbd_pkg::RST_SOURCE_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (rbd_pkg::reg_index_t'(cfg_index))
        rbd_pkg::REG_SOURCE_WIDTH:  source_width_r  <= cfg_data[10:0];
        rbd_pkg::REG_SOURCE_HEIGHT: source_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = take;
  assign accept    = in_tvalid && in_tready;

  rbd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW),
    .AW        (AW)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .px            (in_tdata),
    .source_width  (source_width_r),
    .source_height (source_height_r),
    .s0            (s0),
    .mem_req       (mem_req),
    .mem_addr      (mem_addr),
    .mem_wdata     (mem_wdata)
  );

  // a write and the read of the same entry are a full row apart
  rbd_line_ram #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW),
    .DW    (rbd_pkg::SUM_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .re    (mem_req.re),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  rbd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .s0         (s0),
    .rd_data    (mem_rdata),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
